>>> hdl/ssmp_pkg.sv
// Package with the shared constants, types and control structures of the motion profiler.
`timescale 1ns / 1ps

package ssmp_pkg;

    localparam int NUM_CHANNELS = 4;
    localparam int CH_W         = 2;
    localparam int FX_W         = 20;
    localparam int DUR_W        = 20;
    localparam int DIV_W        = 36;
    localparam int DIV_STEPS    = DIV_W;
    localparam int DIV_CNT_W    = 6;

    localparam logic [11:0]      PULSE_MIN_RST  = 12'd150;
    localparam logic [11:0]      PULSE_MAX_RST  = 12'd600;
    localparam logic [DUR_W-1:0] DURATION_RST   = 20'd4000;
    localparam logic [12:0]      ANGLE_OFFSET   = 13'd900;
    localparam logic [19:0]      EASE_THREE     = 20'd196608;
    localparam int               DUR_TOLERANCE  = 50;

    // The angle map divides 32 times the product by 225 as a multiply by ceil(2^36 / 225)
    // followed by a 36-bit shift, which is exact for numerators below 2^28. Adding 224 first
    // turns the floor into a ceiling for negative products.
    localparam logic [27:0]      MAP_ROUND      = 28'd224;
    localparam logic [31:0]      MAP_RECIP      = 32'd305419897;

    localparam logic REG_PULSE_MIN = 1'b0;
    localparam logic REG_PULSE_MAX = 1'b1;

    localparam logic KIND_SET  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SET_MUL,
        ST_SET_RECIP,
        ST_SET_COMMIT,
        ST_TICK_CHECK,
        ST_TICK_WAIT,
        ST_TICK_SQ,
        ST_TICK_EASE,
        ST_TICK_DELTA,
        ST_TICK_UPD,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_MAP,
        MUL_RECIP,
        MUL_SQ,
        MUL_EASE,
        MUL_DELTA
    } mul_op_t;

    typedef struct packed {
        logic     load_in;
        mul_op_t  mul_op;
        logic     div_start;
        logic     set_commit;
        logic     tick_finish;
        logic     tick_update;
        logic     out_load;
        logic     idx_inc;
    } dp_cmd_t;

    typedef struct packed {
        logic is_tick;
        logic set_apply;
        logic div_done;
        logic ch_moving;
        logic ch_finish;
        logic idx_last;
        logic out_free;
    } dp_status_t;

endpackage

>>> hdl/servo_smoothstep_motion_profiler.sv
// Top level of the four-channel smoothstep servo motion profiler.
// The block takes one item at a time. A set item is decoded and then either ignored or
// applied by a map multiply, a reciprocal multiply and a commit, the two multiplies on the
// shared multiplier that maps the angle into the pulse range (the division by a constant is
// a multiply by its reciprocal). A tick item walks the channels in order: an idle channel is
// only checked, a channel whose move ends is checked and its result transferred, and a channel
// mid-move takes a setup step, 36 divider steps for the progress, three multiplies on the
// shared multiplier, an update and the output transfer. A result waits in an output register;
// the walk stalls only when that register is still full.
`timescale 1ns / 1ps

module servo_smoothstep_motion_profiler
    import ssmp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] channel, [12:2] angle_tenths, [32:13] duration_ms, [64:33] now_ms, rest zero
    input  logic [71:0] s_tdata,
    // [0] kind
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] out_channel, [13:2] pulse_count, [14] move_done, [15] zero
    output logic [15:0] m_tdata,
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [11:0] pulse_min_reg;
    logic [11:0] pulse_max_reg;
    logic        cfg_wr;
    dp_cmd_t     cmd;
    dp_status_t  status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_min_reg <= PULSE_MIN_RST;
            pulse_max_reg <= PULSE_MAX_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_PULSE_MIN)
            begin
                pulse_min_reg <= pwdata[11:0];
            end
            else
            begin
                pulse_max_reg <= pwdata[11:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_PULSE_MIN) ? 32'(pulse_min_reg) : 32'(pulse_max_reg);

    ssmp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ssmp_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .pulse_min (pulse_min_reg),
        .pulse_max (pulse_max_reg),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

>>> hdl/ssmp_div.sv
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module ssmp_div
    import ssmp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DUR_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DUR_W-1:0]     rem_reg, rem_next;
    logic [DUR_W-1:0]     dsr_reg, dsr_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DUR_W:0]       trial;
    logic [DUR_W:0]       diff;
    logic                 ge;

    always_comb
    begin
        trial = {rem_reg, quo_reg[DIV_W-1]};
        ge    = trial >= {1'b0, dsr_reg};
        diff  = trial - {1'b0, dsr_reg};

        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIV_W-2:0], ge};
            rem_next = ge ? diff[DUR_W-1:0] : trial[DUR_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> hdl/ssmp_dp.sv
// Datapath: channel state, input and output registers, shared multiplier and divider.
`timescale 1ns / 1ps

module ssmp_dp
    import ssmp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    input  logic [11:0] pulse_min,
    input  logic [11:0] pulse_max,
    input  logic [71:0] s_tdata,
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    output logic        m_tlast
);

    logic              kind_reg;
    logic [CH_W-1:0]   ch_reg;
    logic [10:0]       ang_reg;
    logic [DUR_W-1:0]  dur_reg;
    logic [31:0]       now_reg;
    logic [CH_W-1:0]   idx_reg, idx_next;

    logic [10:0]       st_angle_reg  [NUM_CHANNELS];
    logic [DUR_W-1:0]  st_dur_reg    [NUM_CHANNELS];
    logic [31:0]       st_time_reg   [NUM_CHANNELS];
    logic [FX_W-1:0]   start_fx_reg  [NUM_CHANNELS];
    logic [FX_W-1:0]   target_fx_reg [NUM_CHANNELS];
    logic [FX_W-1:0]   cur_fx_reg    [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] moving_reg;

    logic [63:0]       mul_reg;
    logic              neg_reg;
    logic              done_flag_reg;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [15:0]       m_tdata_reg;
    logic              m_tlast_reg;

    logic [31:0]       mul_a;
    logic [31:0]       mul_b;
    logic [DIV_W-1:0]  div_dividend;
    logic [DUR_W-1:0]  div_divisor;
    logic              div_done;
    logic [DIV_W-1:0]  div_q;

    logic signed [12:0] ang_ofs;
    logic signed [13:0] span;
    logic [11:0]        ang_abs;
    logic [11:0]        span_abs;
    logic [27:0]        map_num;
    logic [20:0]        map_q;
    logic signed [33:0] fq;
    logic signed [33:0] lo_s;
    logic signed [33:0] hi_s;
    logic signed [33:0] x_s;
    logic [FX_W-1:0]    map_fx;
    logic signed [DUR_W:0] dd;
    logic [31:0]        elapsed;
    logic [15:0]        prog;
    logic signed [FX_W:0] dlt;
    logic [FX_W-1:0]    dlt_abs;
    logic [FX_W-1:0]    step_fx;
    logic [FX_W-1:0]    upd_fx;
    logic               later_moving;

    ssmp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        ang_ofs  = 13'(signed'(ang_reg)) + signed'(ANGLE_OFFSET);
        span     = signed'({2'b00, pulse_max}) - signed'({2'b00, pulse_min});
        ang_abs  = ang_ofs[12] ? 12'(-ang_ofs) : ang_ofs[11:0];
        span_abs = span[13] ? 12'(-span) : span[11:0];

        map_num = {mul_reg[22:0], 5'b00000} + (neg_reg ? MAP_ROUND : 28'd0);
        map_q   = mul_reg[56:36];

        fq   = neg_reg ? -34'(map_q) : 34'(map_q);
        lo_s = signed'(34'({pulse_min, 8'h00}));
        hi_s = signed'(34'({pulse_max, 8'h00}));
        x_s  = lo_s + fq;
        if (x_s < lo_s)
        begin
            map_fx = lo_s[FX_W-1:0];
        end
        else if (x_s > hi_s)
        begin
            map_fx = hi_s[FX_W-1:0];
        end
        else
        begin
            map_fx = x_s[FX_W-1:0];
        end

        dd = signed'({1'b0, st_dur_reg[ch_reg]}) - signed'({1'b0, dur_reg});

        elapsed = now_reg - st_time_reg[idx_reg];
        prog    = div_q[15:0];

        dlt     = signed'({1'b0, target_fx_reg[idx_reg]})
                  - signed'({1'b0, start_fx_reg[idx_reg]});
        dlt_abs = dlt[FX_W] ? FX_W'(-dlt) : dlt[FX_W-1:0];
        step_fx = mul_reg[35:16];
        upd_fx  = dlt[FX_W] ? start_fx_reg[idx_reg] - step_fx
                            : start_fx_reg[idx_reg] + step_fx;

        later_moving = 1'b0;
        for (int j = 0; j < NUM_CHANNELS; j++)
        begin
            if (j > int'(idx_reg) && moving_reg[j])
            begin
                later_moving = 1'b1;
            end
        end

        unique case (cmd.mul_op)
            MUL_MAP:
            begin
                mul_a = 32'(ang_abs);
                mul_b = 32'(span_abs);
            end
            MUL_RECIP:
            begin
                mul_a = 32'(map_num);
                mul_b = MAP_RECIP;
            end
            MUL_SQ:
            begin
                mul_a = 32'(prog);
                mul_b = 32'(prog);
            end
            MUL_EASE:
            begin
                mul_a = mul_reg[31:0];
                mul_b = 32'(EASE_THREE - 20'({prog, 1'b0}));
            end
            MUL_DELTA:
            begin
                mul_a = 32'(dlt_abs);
                mul_b = 32'(mul_reg[47:32]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase

        div_dividend = DIV_W'({elapsed[DUR_W-1:0], 16'h0000});
        div_divisor  = st_dur_reg[idx_reg];

        idx_next = idx_reg;
        if (cmd.load_in)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + 1'b1;
        end

        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            kind_reg <= s_tuser;
            ch_reg   <= s_tdata[1:0];
            ang_reg  <= s_tdata[12:2];
            dur_reg  <= s_tdata[32:13];
            now_reg  <= s_tdata[64:33];
        end
        if (cmd.mul_op != MUL_NONE)
        begin
            mul_reg <= {32'd0, mul_a} * {32'd0, mul_b};
        end
        if (cmd.mul_op == MUL_MAP)
        begin
            neg_reg <= ang_ofs[12] ^ span[13];
        end
        if (cmd.out_load)
        begin
            m_tdata_reg <= {1'b0, done_flag_reg, cur_fx_reg[idx_reg][FX_W-1:8], idx_reg};
            m_tlast_reg <= !later_moving;
        end
        if (cmd.tick_finish)
        begin
            done_flag_reg <= 1'b1;
        end
        else if (cmd.tick_update)
        begin
            done_flag_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            moving_reg   <= '0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                st_angle_reg[i]  <= '0;
                st_dur_reg[i]    <= DURATION_RST;
                st_time_reg[i]   <= '0;
                start_fx_reg[i]  <= '0;
                target_fx_reg[i] <= '0;
                cur_fx_reg[i]    <= '0;
            end
        end
        else
        begin
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cmd.set_commit)
            begin
                start_fx_reg[ch_reg]  <= cur_fx_reg[ch_reg];
                target_fx_reg[ch_reg] <= map_fx;
                st_angle_reg[ch_reg]  <= ang_reg;
                st_dur_reg[ch_reg]    <= dur_reg;
                st_time_reg[ch_reg]   <= now_reg;
                moving_reg[ch_reg]    <= 1'b1;
            end
            if (cmd.tick_finish)
            begin
                cur_fx_reg[idx_reg] <= target_fx_reg[idx_reg];
                moving_reg[idx_reg] <= 1'b0;
            end
            else if (cmd.tick_update)
            begin
                cur_fx_reg[idx_reg] <= upd_fx;
            end
        end
    end

    always_comb
    begin
        status.is_tick   = kind_reg == KIND_TICK;
        status.set_apply = (int'(ch_reg) < NUM_CHANNELS)
                           && !((ang_reg == st_angle_reg[ch_reg])
                                && (dd > -(DUR_TOLERANCE)) && (dd < DUR_TOLERANCE));
        status.div_done  = div_done;
        status.ch_moving = moving_reg[idx_reg];
        status.ch_finish = (st_dur_reg[idx_reg] == '0) || (elapsed >= 32'(st_dur_reg[idx_reg]));
        status.idx_last  = idx_reg == CH_W'(NUM_CHANNELS - 1);
        status.out_free  = !m_tvalid_reg || m_tready;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

>>> hdl/ssmp_ctrl.sv
// Controller state machine that sequences set items and channel walks of tick items.
`timescale 1ns / 1ps

module ssmp_ctrl
    import ssmp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '{load_in: 1'b0, mul_op: MUL_NONE, div_start: 1'b0,
                       set_commit: 1'b0, tick_finish: 1'b0, tick_update: 1'b0,
                       out_load: 1'b0, idx_inc: 1'b0};
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                priority if (status.is_tick)
                begin
                    state_next = ST_TICK_CHECK;
                end
                else if (status.set_apply)
                begin
                    state_next = ST_SET_MUL;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SET_MUL:
            begin
                cmd.mul_op = MUL_MAP;
                state_next = ST_SET_RECIP;
            end
            ST_SET_RECIP:
            begin
                cmd.mul_op = MUL_RECIP;
                state_next = ST_SET_COMMIT;
            end
            ST_SET_COMMIT:
            begin
                cmd.set_commit = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_TICK_CHECK:
            begin
                priority if (!status.ch_moving)
                begin
                    if (status.idx_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                    end
                end
                else if (status.ch_finish)
                begin
                    cmd.tick_finish = 1'b1;
                    state_next      = ST_EMIT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_TICK_WAIT;
                end
            end
            ST_TICK_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = ST_TICK_SQ;
                end
            end
            ST_TICK_SQ:
            begin
                cmd.mul_op = MUL_SQ;
                state_next = ST_TICK_EASE;
            end
            ST_TICK_EASE:
            begin
                cmd.mul_op = MUL_EASE;
                state_next = ST_TICK_DELTA;
            end
            ST_TICK_DELTA:
            begin
                cmd.mul_op = MUL_DELTA;
                state_next = ST_TICK_UPD;
            end
            ST_TICK_UPD:
            begin
                cmd.tick_update = 1'b1;
                state_next      = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (status.idx_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_TICK_CHECK;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/ssmp_checker.sv
// Port-level checker for the motion profiler and its bind to the top level.
`timescale 1ns / 1ps

module ssmp_checker
    import ssmp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // The block works on one item at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while busy");

    // A set item never produces a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == KIND_SET |=> !$rose(m_tvalid) ##1 !$rose(m_tvalid))
        else $error("result after a set item");

endmodule

bind servo_smoothstep_motion_profiler ssmp_checker u_ssmp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
